// ===== rtl/core/gfau_pkg.sv =====
// Shared types, constants and the primitive polynomial lookup of the GF(2^m) unit.
// No dependencies; used by every module under rtl/core.
package gfau_pkg;

  localparam int ELEM_W         = 8;
  localparam int CMD_W          = 2;
  localparam int DEG_W          = 4;
  localparam int MAX_DEGREE_DEF = 8;
  localparam logic [DEG_W-1:0] DEGREE_RST = 4'd8;

  // operation codes carried in the low bits of the input word
  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  // one table write from the rebuild sequencer: antilog[idx] = elem, log[elem] = idx
  typedef struct packed {
    logic              we;
    logic [ELEM_W-1:0] idx;
    logic [ELEM_W-1:0] elem;
  } tbl_wr_t;

  // primitive polynomial for each degree, x^m term included
  function automatic logic [ELEM_W:0] prim_poly(input logic [DEG_W-1:0] m);
    logic [ELEM_W:0] p;
    unique case (m)
      4'd1:    p = 9'd3;
      4'd2:    p = 9'd7;
      4'd3:    p = 9'd11;
      4'd4:    p = 9'd19;
      4'd5:    p = 9'd37;
      4'd6:    p = 9'd67;
      4'd7:    p = 9'd137;
      4'd8:    p = 9'd285;
      default: p = 9'd0;
    endcase
    return p;
  endfunction

endpackage

// ===== rtl/core/gfau_table_gen.sv =====
// Log/antilog table rebuild sequencer: steps alpha^i through the field LFSR.
// Depends on gfau_pkg (tbl_wr_t, prim_poly).
module gfau_table_gen #(
  parameter int MAX_DEGREE = gfau_pkg::MAX_DEGREE_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [gfau_pkg::DEG_W-1:0]    eff_m,
  output logic                          busy,
  output gfau_pkg::tbl_wr_t             wr
);

  logic [MAX_DEGREE-1:0] cnt;
  logic [MAX_DEGREE-1:0] elem;
  logic [MAX_DEGREE-1:0] elem_next;
  logic [MAX_DEGREE-1:0] order;
  logic [MAX_DEGREE:0]   size_w;
  logic [MAX_DEGREE:0]   shifted;
  logic [MAX_DEGREE:0]   poly;
  logic [MAX_DEGREE:0]   full;
  logic                  carry;

  // multiply by alpha and reduce
  always_comb begin
    order     = MAX_DEGREE'((9'd1 << eff_m) - 9'd1);
    size_w    = (MAX_DEGREE+1)'(1) << eff_m;
    shifted   = {elem, 1'b0};
    carry     = |(shifted & size_w);
    poly      = (MAX_DEGREE+1)'(gfau_pkg::prim_poly(eff_m));
    full      = shifted ^ (carry ? poly : '0);
    elem_next = full[MAX_DEGREE-1:0] & order;
  end

  // sweep over the group order, restarted by reset and each degree write
  always_ff @(posedge clk) begin
    if (rst || start) begin
      busy <= 1'b1;
      cnt  <= '0;
      elem <= MAX_DEGREE'(1);
    end else if (busy) begin
      if (cnt == order - MAX_DEGREE'(1)) begin
        busy <= 1'b0;
      end
      cnt  <= cnt + MAX_DEGREE'(1);
      elem <= elem_next;
    end
  end

  assign wr.we   = busy;
  assign wr.idx  = gfau_pkg::ELEM_W'(cnt);
  assign wr.elem = gfau_pkg::ELEM_W'(elem);

endmodule

// ===== rtl/core/gfau_datapath.sv =====
// Three-stage operation pipeline around the log and antilog memories.
// Depends on gfau_pkg (cmd_t, tbl_wr_t, widths).
module gfau_datapath #(
  parameter int MAX_DEGREE = gfau_pkg::MAX_DEGREE_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [gfau_pkg::DEG_W-1:0]     eff_m,
  input  gfau_pkg::tbl_wr_t              wr,
  input  logic                           in_accept,
  input  gfau_pkg::cmd_t                 in_cmd,
  input  logic [gfau_pkg::ELEM_W-1:0]    in_a,
  input  logic [gfau_pkg::ELEM_W-1:0]    in_b,
  output logic                           advance,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [gfau_pkg::ELEM_W-1:0]    out_result
);

  localparam int DEPTH = 1 << MAX_DEGREE;
  localparam int EW    = gfau_pkg::ELEM_W;

  logic [MAX_DEGREE-1:0] log_mem  [DEPTH];
  logic [MAX_DEGREE-1:0] alog_mem [DEPTH];

  logic [EW-1:0]         mask;
  logic [EW-1:0]         a_m;
  logic [EW-1:0]         b_m;

  // stage 1: operands in flight, log reads pending
  logic                  s1_valid;
  gfau_pkg::cmd_t        s1_cmd;
  logic [EW-1:0]         s1_a;
  logic [EW-1:0]         s1_b;
  logic [EW-1:0]         s1_mask;
  logic [MAX_DEGREE-1:0] la;
  logic [MAX_DEGREE-1:0] lb;

  // stage 2: antilog read pending
  logic                  s2_valid;
  gfau_pkg::cmd_t        s2_cmd;
  logic [EW-1:0]         s2_xor;
  logic                  s2_zero;
  logic [EW-1:0]         s2_mask;
  logic [MAX_DEGREE-1:0] alog_q;

  logic [MAX_DEGREE-1:0] order;
  logic [MAX_DEGREE:0]   sum;
  logic [MAX_DEGREE:0]   diff;
  logic [MAX_DEGREE-1:0] idx;
  logic [EW-1:0]         result_next;

  assign advance = !out_valid || out_ready;

  assign mask = EW'((9'd1 << eff_m) - 9'd1);
  assign a_m  = in_a & mask;
  assign b_m  = in_b & mask;

  // table fill from the rebuild sequencer
  always_ff @(posedge clk) begin
    if (wr.we) begin
      alog_mem[wr.idx[MAX_DEGREE-1:0]] <= wr.elem[MAX_DEGREE-1:0];
      log_mem[wr.elem[MAX_DEGREE-1:0]] <= wr.idx[MAX_DEGREE-1:0];
    end
  end

  // stage 1 registers and log lookups
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_cmd  <= in_cmd;
      s1_a    <= a_m;
      s1_b    <= b_m;
      s1_mask <= mask;
      la      <= log_mem[a_m[MAX_DEGREE-1:0]];
      lb      <= log_mem[b_m[MAX_DEGREE-1:0]];
    end
  end

  // exponent add or subtract modulo the group order
  always_comb begin
    order = s1_mask[MAX_DEGREE-1:0];
    sum   = {1'b0, la} + {1'b0, lb};
    diff  = {1'b0, la} - {1'b0, lb};
    if (s1_cmd == gfau_pkg::CMD_DIV) begin
      idx = (la < lb) ? (diff[MAX_DEGREE-1:0] + order) : diff[MAX_DEGREE-1:0];
    end else begin
      idx = (sum >= {1'b0, order}) ? MAX_DEGREE'(sum - {1'b0, order})
                                   : sum[MAX_DEGREE-1:0];
    end
  end

  // stage 2 registers and antilog lookup
  always_ff @(posedge clk) begin
    if (advance) begin
      s2_cmd  <= s1_cmd;
      s2_xor  <= s1_a ^ s1_b;
      s2_zero <= (s1_a == '0) || (s1_b == '0);
      s2_mask <= s1_mask;
      alog_q  <= alog_mem[idx];
    end
  end

  // result select
  always_comb begin
    case (s2_cmd) inside
      gfau_pkg::CMD_ADD, gfau_pkg::CMD_SUB: result_next = s2_xor;
      default: result_next = s2_zero ? '0 : (EW'(alog_q) & s2_mask);
    endcase
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= in_accept;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result_next;
    end
  end

endmodule

// ===== rtl/core/gf2m_arithmetic_unit.sv =====
// Top level of the GF(2^m) arithmetic unit: degree register, table rebuild, pipeline.
// Depends on gfau_pkg, gfau_table_gen and gfau_datapath.
//
// Usage:
//   s_axis carries one operation word per transfer: command (add, subtract,
//   multiply, divide) and two field elements. m_axis returns one result word
//   per operation, in order. Both sides handshake on tvalid && tready.
//   Add and subtract are XOR; multiply and divide go through log and antilog
//   memories, so a zero operand or a zero divisor yields zero.
//   From input transfer to m_axis_tvalid a word passes the log read, antilog
//   read and output registers. Throughput is one word per cycle while m_axis
//   is ready and no table rebuild is running.
//   A stall on m_axis freezes the whole pipeline; s_axis_tready drops in the
//   same cycle, so no word is dropped or repeated.
//   After reset, and after each write of cfg_wdata (field degree, clamped to
//   1..MAX_DEGREE, reset value 8), the tables are rebuilt, 2^m - 1 entries
//   (255 after reset); s_axis_tready stays low meanwhile. Write the degree
//   only while the unit is idle.
module gf2m_arithmetic_unit #(
  parameter int MAX_DEGREE = gfau_pkg::MAX_DEGREE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: field degree m
  input  logic        cfg_wen,
  input  logic [3:0]  cfg_wdata,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [1:0] command, [9:2] operand_a, [17:10] operand_b
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [7:0] result
);

  logic [gfau_pkg::DEG_W-1:0] field_degree;
  logic [gfau_pkg::DEG_W-1:0] eff_m;
  logic                       busy;
  logic                       advance;
  logic                       in_accept;
  gfau_pkg::tbl_wr_t          wr;
  gfau_pkg::cmd_t             in_cmd;

  // degree register
  always_ff @(posedge clk) begin
    if (rst) begin
      field_degree <= gfau_pkg::DEGREE_RST;
    end else if (cfg_wen) begin
      field_degree <= cfg_wdata;
    end
  end

  // clamp degree into the supported range
  always_comb begin
    if (field_degree == '0) begin
      eff_m = gfau_pkg::DEG_W'(1);
    end else if (field_degree > gfau_pkg::DEG_W'(MAX_DEGREE)) begin
      eff_m = gfau_pkg::DEG_W'(MAX_DEGREE);
    end else begin
      eff_m = field_degree;
    end
  end

  assign s_axis_tready = advance && !busy;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign in_cmd        = gfau_pkg::cmd_t'(s_axis_tdata[1:0]);

  gfau_table_gen #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_table_gen (
    .clk   (clk),
    .rst   (rst),
    .start (cfg_wen),
    .eff_m (eff_m),
    .busy  (busy),
    .wr    (wr)
  );

  gfau_datapath #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .eff_m      (eff_m),
    .wr         (wr),
    .in_accept  (in_accept),
    .in_cmd     (in_cmd),
    .in_a       (s_axis_tdata[9:2]),
    .in_b       (s_axis_tdata[17:10]),
    .advance    (advance),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (m_axis_tdata)
  );

endmodule

// ===== sim/gf2m_arithmetic_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for gf2m_arithmetic_unit: add/sub/mul/div over GF(2^m), all degrees.
// Depends on gfau_pkg and the gf2m_arithmetic_unit RTL; carries its own log/antilog predictor.
module gf2m_arithmetic_unit_tb;

  // one operation word as the sender sees it
  typedef struct packed {
    gfau_pkg::cmd_t cmd;
    logic [7:0]     op_a;
    logic [7:0]     op_b;
  } gf_op_t;

  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [3:0]  cfg_wdata = 4'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = 24'd0;  // [1:0] command, [9:2] operand_a, [17:10] operand_b
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;          // [7:0] result

  // predictor state: effective degree and its log/antilog tables
  int          field_m;
  logic [7:0]  antilog_mem [0:255];
  logic [7:0]  log_mem [0:255];
  int unsigned field_poly [1:8] = '{3, 7, 11, 19, 37, 67, 137, 285};

  gf_op_t      pending_ops [$];
  logic [7:0]  expected_results [$];
  gf_op_t      next_op;
  logic        op_taken = 1'b0;
  int          ops_queued = 0;
  int          ops_taken = 0;
  int          err_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_epoch = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  gf2m_arithmetic_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk = ~clk;

  // register value -> effective degree, then regenerate the tables by stepping alpha
  task automatic load_degree(logic [3:0] value);
    int unsigned size;
    int unsigned elem;
    field_m = (value == 4'd0) ? 1 : (value > 4'd8) ? 8 : int'(value);
    size = 1 << field_m;
    elem = 1;
    for (int i = 0; i < 256; i++) begin
      antilog_mem[i] = 8'd0;
      log_mem[i]     = 8'd0;
    end
    for (int i = 0; i < size - 1; i++) begin
      antilog_mem[i]    = elem[7:0];
      log_mem[elem[7:0]] = i[7:0];
      elem = elem << 1;
      if (elem & size) elem = elem ^ field_poly[field_m];
      elem = elem & (size - 1);
    end
  endtask

  function automatic logic [7:0] gf_result(gfau_pkg::cmd_t cmd, logic [7:0] a, logic [7:0] b);
    int unsigned mask;
    int unsigned ea;
    int unsigned eb;
    int unsigned pos;
    mask = (1 << field_m) - 1;
    ea = a & mask;
    eb = b & mask;
    if (cmd == gfau_pkg::CMD_ADD || cmd == gfau_pkg::CMD_SUB) return 8'((ea ^ eb) & mask);
    if (ea == 0 || eb == 0) return 8'd0;
    if (cmd == gfau_pkg::CMD_MUL) pos = (log_mem[ea] + log_mem[eb]) % mask;
    else pos = (log_mem[ea] + mask - log_mem[eb]) % mask;
    return 8'(antilog_mem[pos] & mask);
  endfunction

  // sender: present the next word once the current one has gone
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || op_taken) begin
      if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_op = pending_ops.pop_front();
        s_axis_tdata  <= {6'd0, next_op.op_b, next_op.op_a, next_op.cmd};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_epoch != hold_seen) begin
      hold_seen     <= hold_epoch;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on input words, check output words in order
  always @(posedge clk) begin
    op_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(gf_result(gfau_pkg::cmd_t'(s_axis_tdata[1:0]),
                                             s_axis_tdata[9:2], s_axis_tdata[17:10]));
        ops_taken <= ops_taken + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result word: actual %0h", m_axis_tdata);
          err_count <= err_count + 1;
        end else if (m_axis_tdata !== expected_results[0]) begin
          $error("result mismatch: expected %0h, actual %0h",
                 expected_results[0], m_axis_tdata);
          err_count <= err_count + 1;
          void'(expected_results.pop_front());
        end else begin
          void'(expected_results.pop_front());
        end
      end
    end
  end

  task automatic queue_op(gfau_pkg::cmd_t cmd, logic [7:0] a, logic [7:0] b);
    gf_op_t op;
    op.cmd  = cmd;
    op.op_a = a;
    op.op_b = b;
    pending_ops.push_back(op);
    ops_queued++;
  endtask

  // wait until every word sent has come back, then let the pipeline settle
  task automatic drain();
    while (ops_taken != ops_queued || expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_degree(logic [3:0] value);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    load_degree(value);
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  // random words, biased toward zero operands, in-field operands and equal operands
  task automatic queue_random(int count);
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] mask;
    int         pick;
    mask = 8'((1 << field_m) - 1);
    for (int i = 0; i < count; i++) begin
      a = 8'($urandom_range(255));
      b = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 8) a = 8'd0;
      else if (pick < 16) b = 8'd0;
      else if (pick < 30) begin
        a = a & mask;
        b = b & mask;
      end else if (pick < 35) b = a;
      queue_op(gfau_pkg::cmd_t'($urandom_range(3)), a, b);
    end
  endtask

  initial begin
    logic [3:0] degree_order [16] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd2, 4'd4, 4'd5, 4'd6,
                                      4'd7, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd3};
    load_degree(gfau_pkg::DEGREE_RST);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes and zero handling at the reset degree
    queue_op(gfau_pkg::CMD_ADD, 8'h00, 8'h00);
    queue_op(gfau_pkg::CMD_ADD, 8'hff, 8'hff);
    queue_op(gfau_pkg::CMD_SUB, 8'hff, 8'h00);
    queue_op(gfau_pkg::CMD_SUB, 8'h55, 8'haa);
    queue_op(gfau_pkg::CMD_MUL, 8'h00, 8'h37);
    queue_op(gfau_pkg::CMD_MUL, 8'h9c, 8'h00);
    queue_op(gfau_pkg::CMD_MUL, 8'h01, 8'h01);
    queue_op(gfau_pkg::CMD_MUL, 8'hff, 8'hff);
    queue_op(gfau_pkg::CMD_MUL, 8'h80, 8'h02);
    queue_op(gfau_pkg::CMD_DIV, 8'h5a, 8'h00);
    queue_op(gfau_pkg::CMD_DIV, 8'h00, 8'h5a);
    queue_op(gfau_pkg::CMD_DIV, 8'h00, 8'h00);
    queue_op(gfau_pkg::CMD_DIV, 8'hff, 8'hff);
    queue_op(gfau_pkg::CMD_DIV, 8'h01, 8'hff);
    queue_op(gfau_pkg::CMD_DIV, 8'h80, 8'h02);
    drain();

    // directed: operand bits above m must be ignored
    write_degree(4'd3);
    queue_op(gfau_pkg::CMD_ADD, 8'hff, 8'hf0);
    queue_op(gfau_pkg::CMD_MUL, 8'hf9, 8'hfa);
    queue_op(gfau_pkg::CMD_DIV, 8'hff, 8'h08);
    queue_op(gfau_pkg::CMD_DIV, 8'hf8, 8'h03);
    queue_op(gfau_pkg::CMD_MUL, 8'h07, 8'h07);
    queue_op(gfau_pkg::CMD_SUB, 8'h0f, 8'hf7);
    drain();

    // random phases, one degree setting each, rotating through idle patterns
    for (int p = 0; p < 16; p++) begin
      write_degree(degree_order[p]);
      @(posedge clk);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      queue_random(108);
      // back up the pipeline while the sender keeps pushing
      if (p == 4) begin
        @(posedge clk);
        hold_epoch++;
      end
      drain();
    end

    if (err_count == 0) begin
      $display("gf2m_arithmetic_unit_tb: done, clean");
    end else begin
      $display("gf2m_arithmetic_unit_tb: done, errors");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("gf2m_arithmetic_unit_tb: done, errors");
    $finish;
  end

endmodule
